// ===== rtl/sdu_pkg.sv =====
// ----------------------------------------------------------------------------
// sdu_pkg
// shared types and constants of the register-mapped signed divide unit
// ----------------------------------------------------------------------------
package sdu_pkg;

    localparam int DATA_W        = 32;
    localparam int NUM_BANKS_DEF = 2;
    localparam int DIV_STEPS     = 32;

    localparam logic [DATA_W-1:0] SAT_POS = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [1:0] {
        FUNC_WR_DIVISOR = 2'd0,
        FUNC_DIV32      = 2'd1,
        FUNC_WR_HIGH    = 2'd2,
        FUNC_DIV64      = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic                    start;
        logic [2*DATA_W-1:0]     dividend;
        logic [DATA_W-1:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic [2*DATA_W-1:0]     quotient;
        logic [DATA_W-1:0]       remainder;
    } div_rsp_t;

endpackage

// ===== rtl/signed_divide_unit_regs.sv =====
// ----------------------------------------------------------------------------
// signed_divide_unit_regs
// register-mapped signed 32/32 and 64/32 divider with per-processor banks
// ----------------------------------------------------------------------------
// each input transfer (func, unit, data) writes one register of the bank
// chosen by unit: divisor, dividend high word, or a start register that
// launches a 32/32 divide (short dividend) or a 64/32 divide (low word).
// every input transfer gives exactly one output transfer carrying the
// bank's short dividend, high and low words after the access, plus an
// overflow flag set when a quotient saturated.
// a plain register write returns its result through the LOAD and DONE
// states after the input transfer; a divide also passes through DIV, where
// it waits on the shared two-bit-per-pass divider. in_stall is high from
// the input transfer until the result is loaded into the output register,
// so one item is in work at a time; a finished result waiting on out_stall
// does not block the next input transfer, but the following result holds
// until the output register is free. reset clears all bank registers to
// zero and empties the output register.
// ----------------------------------------------------------------------------
module signed_divide_unit_regs
    import sdu_pkg::*;
#(
    parameter int NUM_BANKS = NUM_BANKS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic              unit,
    input  logic [DATA_W-1:0] data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] short_quotient,
    output logic [DATA_W-1:0] remainder_word,
    output logic [DATA_W-1:0] quotient_word,
    output logic              overflowed
);

    state_t              state_reg;
    state_t              state_next;

    logic [DATA_W-1:0]   divisor_reg        [NUM_BANKS];
    logic [DATA_W-1:0]   short_dividend_reg [NUM_BANKS];
    logic [DATA_W-1:0]   high_word_reg      [NUM_BANKS];
    logic [DATA_W-1:0]   low_word_reg       [NUM_BANKS];

    func_t               func_reg;
    logic                unit_reg;
    logic [DATA_W-1:0]   data_reg;
    logic                neg_n_reg;
    logic                neg_q_reg;
    logic                zero_div_reg;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   short_quotient_reg;
    logic [DATA_W-1:0]   remainder_word_reg;
    logic [DATA_W-1:0]   quotient_word_reg;
    logic                overflowed_reg;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic                bank_ok;
    logic                is_divide;
    logic                out_free;
    logic [DATA_W-1:0]   div_cur;
    logic [DATA_W-1:0]   sh_cur;
    logic [DATA_W-1:0]   hi_cur;
    logic [DATA_W-1:0]   lo_cur;
    logic [2*DATA_W-1:0] num_full;
    logic [2*DATA_W-1:0] num_mag;
    logic [DATA_W-1:0]   den_mag;

    logic [2*DATA_W-1:0] q_full;
    logic                sat_pos;
    logic                sat_neg;
    logic [DATA_W-1:0]   quo_fix;
    logic [DATA_W-1:0]   rem_fix;
    logic [DATA_W-1:0]   dv_new;
    logic [DATA_W-1:0]   sh_new;
    logic [DATA_W-1:0]   hi_new;
    logic [DATA_W-1:0]   lo_new;
    logic                ovf_new;

    sdu_div_core u_div_core (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign bank_ok   = int'(unit_reg) < NUM_BANKS;
    assign is_divide = (func_reg == FUNC_DIV32) || (func_reg == FUNC_DIV64);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    assign div_cur = divisor_reg[unit_reg];
    assign sh_cur  = short_dividend_reg[unit_reg];
    assign hi_cur  = high_word_reg[unit_reg];
    assign lo_cur  = low_word_reg[unit_reg];

    // operand magnitudes for the divider
    always_comb
    begin
        if (func_reg == FUNC_DIV32)
        begin
            num_full = {{DATA_W{data_reg[DATA_W-1]}}, data_reg};
        end
        else
        begin
            num_full = {hi_cur, data_reg};
        end
        num_mag = num_full[2*DATA_W-1] ? (~num_full + 1'b1) : num_full;
        den_mag = div_cur[DATA_W-1] ? (~div_cur + 1'b1) : div_cur;
    end

    assign div_req.start    = (state_reg == ST_LOAD) && is_divide && bank_ok
                              && (div_cur != '0);
    assign div_req.dividend = num_mag;
    assign div_req.divisor  = den_mag;

    // sign fix-up and saturation
    always_comb
    begin
        q_full  = div_rsp.quotient;
        sat_pos = !neg_q_reg && (q_full[2*DATA_W-1:DATA_W-1] != '0);
        sat_neg = neg_q_reg && ((q_full[2*DATA_W-1:DATA_W] != '0)
                  || (q_full[DATA_W-1] && (q_full[DATA_W-2:0] != '0)));
        if (sat_pos)
        begin
            quo_fix = SAT_POS;
        end
        else if (sat_neg)
        begin
            quo_fix = SAT_NEG;
        end
        else if (neg_q_reg)
        begin
            quo_fix = ~q_full[DATA_W-1:0] + 1'b1;
        end
        else
        begin
            quo_fix = q_full[DATA_W-1:0];
        end
        rem_fix = neg_n_reg ? (~div_rsp.remainder + 1'b1) : div_rsp.remainder;
    end

    // new bank contents
    always_comb
    begin
        dv_new  = div_cur;
        sh_new  = sh_cur;
        hi_new  = hi_cur;
        lo_new  = lo_cur;
        ovf_new = 1'b0;
        case (func_reg)
            FUNC_WR_DIVISOR:
            begin
                dv_new = data_reg;
            end
            FUNC_DIV32:
            begin
                if (zero_div_reg)
                begin
                    sh_new = data_reg;
                    hi_new = '0;
                    lo_new = '0;
                end
                else
                begin
                    sh_new  = quo_fix;
                    hi_new  = rem_fix;
                    lo_new  = quo_fix;
                    ovf_new = sat_pos || sat_neg;
                end
            end
            FUNC_WR_HIGH:
            begin
                hi_new = data_reg;
            end
            FUNC_DIV64:
            begin
                if (zero_div_reg)
                begin
                    hi_new = '0;
                    lo_new = '0;
                end
                else
                begin
                    hi_new  = rem_fix;
                    lo_new  = quo_fix;
                    ovf_new = sat_pos || sat_neg;
                end
            end
            default:
            begin
                dv_new = div_cur;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = div_req.start ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // input capture and operand signs
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            func_reg <= func_t'(func);
            unit_reg <= unit;
            data_reg <= data;
        end
        if (state_reg == ST_LOAD)
        begin
            neg_n_reg    <= num_full[2*DATA_W-1];
            neg_q_reg    <= num_full[2*DATA_W-1] ^ div_cur[DATA_W-1];
            zero_div_reg <= (div_cur == '0);
        end
    end

    // register banks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BANKS; i++)
            begin
                divisor_reg[i]        <= '0;
                short_dividend_reg[i] <= '0;
                high_word_reg[i]      <= '0;
                low_word_reg[i]       <= '0;
            end
        end
        else if (state_reg == ST_DONE && out_free && bank_ok)
        begin
            divisor_reg[unit_reg]        <= dv_new;
            short_dividend_reg[unit_reg] <= sh_new;
            high_word_reg[unit_reg]      <= hi_new;
            low_word_reg[unit_reg]       <= lo_new;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            short_quotient_reg <= bank_ok ? sh_new : '0;
            remainder_word_reg <= bank_ok ? hi_new : '0;
            quotient_word_reg  <= bank_ok ? lo_new : '0;
            overflowed_reg     <= bank_ok && ovf_new;
        end
    end

    assign out_valid      = out_valid_reg;
    assign short_quotient = short_quotient_reg;
    assign remainder_word = remainder_word_reg;
    assign quotient_word  = quotient_word_reg;
    assign overflowed     = overflowed_reg;

`ifndef SYNTHESIS
    a_div_state_has_core: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_rsp.busy || div_rsp.done))
        else $error("waiting on divider that is not running");

    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && overflowed_reg)
        |-> ((quotient_word_reg == SAT_POS) || (quotient_word_reg == SAT_NEG)))
        else $error("overflow flag without saturated quotient");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divide started while divider busy");
`endif

endmodule

// ===== rtl/sdu_div_core.sv =====
// ----------------------------------------------------------------------------
// sdu_div_core
// iterative unsigned 64 by 32 divider, two quotient bits per pass
// ----------------------------------------------------------------------------
module sdu_div_core
    import sdu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   den_reg;
    logic [2*DATA_W-1:0] quo_reg;
    logic [STEP_W-1:0]   count_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DATA_W:0]     trial1;
    logic [DATA_W:0]     trial2;
    logic [DATA_W:0]     diff1;
    logic [DATA_W:0]     diff2;
    logic                ge1;
    logic                ge2;
    logic [DATA_W-1:0]   rem1;
    logic [DATA_W-1:0]   rem2;

    always_comb
    begin
        trial1 = {rem_reg, quo_reg[2*DATA_W-1]};
        diff1  = trial1 - {1'b0, den_reg};
        ge1    = trial1 >= {1'b0, den_reg};
        rem1   = ge1 ? diff1[DATA_W-1:0] : trial1[DATA_W-1:0];
        trial2 = {rem1, quo_reg[2*DATA_W-2]};
        diff2  = trial2 - {1'b0, den_reg};
        ge2    = trial2 >= {1'b0, den_reg};
        rem2   = ge2 ? diff2[DATA_W-1:0] : trial2[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem2;
            quo_reg <= {quo_reg[2*DATA_W-3:0], ge1, ge2};
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < den_reg))
        else $error("partial remainder not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("done without a running divide");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");
`endif

endmodule
